@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BGBA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BGBA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

@@ hdl/bgba_pkg.sv @@
package bgba_pkg;

	localparam int GROUP_W    = 4;
	localparam int BPG_W      = 14;
	localparam int GRPS_W     = 5;
	localparam int BLK_W      = 17;
	localparam int TOT_W      = 18;
	localparam int BIT_W      = 3;
	localparam int BYTE_W     = BPG_W - BIT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = BPG_W;

	localparam int BPG_RESET    = 8192;
	localparam int GROUPS_RESET = 16;

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BPG    = 2'd0,
		CFG_GROUPS = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_SCAN,
		T_FIN
	} top_state_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} scan_state_t;

	typedef struct packed {
		logic               start;
		logic               clear;
		logic [GROUP_W-1:0] group;
		logic [BYTE_W-1:0]  nbytes;
	} scan_req_t;

	typedef struct packed {
		logic              rdy;
		logic              done;
		logic              found;
		logic [BYTE_W-1:0] byte_idx;
		logic [BIT_W-1:0]  bit_idx;
	} scan_res_t;

	// position of the lowest clear bit; byte must not be full
	function automatic logic [BIT_W-1:0] lowest_clear(input logic [7:0] v);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int j = 7; j >= 0; j--) begin
			if (!v[j]) begin
				pos = BIT_W'(j);
			end
		end
		return pos;
	endfunction

endpackage

@@ hdl/bgba_ram.sv @@
module bgba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/bgba_scan.sv @@
`include "assert_macros.svh"

module bgba_scan #(
	parameter int NUM_GROUPS = 16,
	parameter int ROW_BYTES  = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bgba_pkg::scan_req_t req,
	output bgba_pkg::scan_res_t res
);

	import bgba_pkg::*;

	localparam int DEPTH = NUM_GROUPS * ROW_BYTES;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	scan_state_t         state_q, state_d;
	logic [AW-1:0]       clr_addr_q;
	logic [AW-1:0]       row_base_q;
	logic [BYTE_W-1:0]   nbytes_q;
	logic [BYTE_W:0]     idx_q;
	logic                rd_vld_s1;
	logic [BYTE_W-1:0]   rd_idx_s1;
	logic [AW-1:0]       rd_addr_s1;
	logic                found_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [BIT_W-1:0]    bit_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [7:0]          ram_rdata;

	logic                in_scan;
	logic                hit;
	logic                last_miss;
	logic                empty;
	logic                finish;
	logic                issue;
	logic                clr_last;
	logic [BIT_W-1:0]    hit_bit;

	bgba_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read data of the previous cycle's address is checked here
	assign in_scan   = (state_q == ST_SCAN);
	assign hit_bit   = lowest_clear(ram_rdata);
	assign hit       = in_scan && rd_vld_s1 && (ram_rdata != FULL_BYTE);
	assign last_miss = in_scan && rd_vld_s1 && (ram_rdata == FULL_BYTE)
		&& (rd_idx_s1 == nbytes_q - BYTE_W'(1));
	assign empty     = in_scan && (nbytes_q == '0);
	assign finish    = hit || last_miss || empty;
	assign issue     = in_scan && (idx_q < {1'b0, nbytes_q}) && !finish;
	assign clr_last  = (clr_addr_q == AW'(DEPTH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		if (req.clear) begin
			state_d = ST_CLEAR;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = ram_rdata | (8'h01 << hit_bit);
		ram_raddr = AW'(row_base_q + AW'(idx_q));
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_SCAN: begin
				ram_we = hit;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			rd_vld_s1  <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (req.clear) begin
				clr_addr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + (BYTE_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			row_base_q <= AW'(32'(req.group) * ROW_BYTES);
			nbytes_q   <= req.nbytes;
		end
		rd_idx_s1  <= idx_q[BYTE_W-1:0];
		rd_addr_s1 <= ram_raddr;
		if (finish) begin
			found_q <= hit;
			byte_q  <= rd_idx_s1;
			bit_q   <= hit_bit;
		end
	end

	assign res.rdy      = (state_q == ST_IDLE);
	assign res.done     = finish;
	assign res.found    = found_q;
	assign res.byte_idx = byte_q;
	assign res.bit_idx  = bit_q;

	`BGBA_ASSERT_NEVER(a_no_write_idle, clk, arst_n, ram_we && state_q == ST_IDLE,
		"bitmap written while scanner idle")
	`BGBA_ASSERT(a_start_scans, clk, arst_n,
		(state_q == ST_IDLE && req.start && !req.clear) |=> (state_q == ST_SCAN),
		"start did not enter scan")
	`BGBA_ASSERT(a_hit_writes, clk, arst_n, hit |-> (ram_we && ram_waddr == rd_addr_s1),
		"found byte not written back")

endmodule

@@ hdl/block_group_bitmap_allocator.sv @@
// Block group bitmap allocator, first fit.
// Input channel (in_valid / in_stall, field group): one allocation request per
// transaction. The request scans that group's usage bitmap one byte per cycle
// from the lowest byte, skips full bytes and takes the lowest clear bit.
// Output channel (out_valid / out_stall): one result per request with found,
// block_number, group_free_left and total_free_left.
// An in-range request is scanned until a byte of the row has a free bit or the row
// ends, with one bitmap RAM read per cycle; a group of fewer than eight blocks
// finishes without a read, and a group out of range skips the scan. The next
// request is taken once the result has been loaded into the output register.
// One request is in work at a time.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data), always ready:
// index 0 blocks_per_group, index 1 groups_in_use. Writing blocks_per_group
// resets all counters and starts a bitmap clear.
// Reset: counters go to full and the bitmap RAM is cleared one byte per cycle,
// all NUM_GROUPS * MAX_BLOCKS_PER_GROUP / 8 bytes (16384 by default), with in_stall
// high until the clear is done. The same clear follows a blocks_per_group write.
// A stalled result stays in the output register; the block still takes one more
// request and holds its result until the output register frees up.
module block_group_bitmap_allocator #(
	parameter int NUM_GROUPS           = 16,
	parameter int MAX_BLOCKS_PER_GROUP = 8192
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bgba_pkg::GROUP_W-1:0]     group,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic [bgba_pkg::BLK_W-1:0]       block_number,
	output logic [bgba_pkg::BPG_W-1:0]       group_free_left,
	output logic [bgba_pkg::TOT_W-1:0]       total_free_left,
	// configuration channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bgba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bgba_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import bgba_pkg::*;

	localparam int ROW_BYTES = MAX_BLOCKS_PER_GROUP / 8;
	localparam int GIDX_W    = NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1;
	// reset values after saturation and rounding to whole bytes
	localparam int RST_EFF   =
		((BPG_RESET > MAX_BLOCKS_PER_GROUP) ? MAX_BLOCKS_PER_GROUP : BPG_RESET) / 8 * 8;
	localparam int RST_GRPS  = (GROUPS_RESET > NUM_GROUPS) ? NUM_GROUPS : GROUPS_RESET;
	localparam int RST_TOT   = RST_GRPS * RST_EFF;

	// saturate to the row size, round down to a multiple of eight
	function automatic logic [BPG_W-1:0] eff_bpg(input logic [BPG_W-1:0] raw);
		logic [BPG_W-1:0] sat;
		sat = (32'(raw) > MAX_BLOCKS_PER_GROUP) ? BPG_W'(MAX_BLOCKS_PER_GROUP) : raw;
		return {sat[BPG_W-1:BIT_W], {BIT_W{1'b0}}};
	endfunction

	top_state_t          state_q, state_d;
	logic [BPG_W-1:0]    bpg_q;
	logic [GRPS_W-1:0]   grps_q;
	logic [BPG_W-1:0]    gfc_q [NUM_GROUPS];
	logic [TOT_W-1:0]    total_q;
	logic [GROUP_W-1:0]  group_q;
	logic                in_range_q;
	logic [BLK_W-1:0]    base_q;
	logic                out_valid_q;
	logic                found_q;
	logic [BLK_W-1:0]    blk_q;
	logic [BPG_W-1:0]    gleft_q;
	logic [TOT_W-1:0]    tleft_q;

	scan_req_t           scan_req;
	scan_res_t           scan_res;

	logic [BPG_W-1:0]    bpg_eff;
	logic [BPG_W-1:0]    bpg_new_eff;
	logic [31:0]         grps_eff;
	logic                in_accept;
	logic                in_range;
	logic                cfg_we;
	logic                clear_all;
	logic                out_load;
	logic [GIDX_W-1:0]   gidx;
	logic                fin_found;
	logic [BPG_W-1:0]    gfc_cur;
	logic [BPG_W-1:0]    gfc_nxt;
	logic [TOT_W-1:0]    tot_nxt;

	bgba_scan #(
		.NUM_GROUPS(NUM_GROUPS),
		.ROW_BYTES (ROW_BYTES)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (scan_req),
		.res   (scan_res)
	);

	assign bpg_eff     = eff_bpg(bpg_q);
	assign bpg_new_eff = eff_bpg(cfg_data[BPG_W-1:0]);
	assign grps_eff    = (32'(grps_q) > NUM_GROUPS) ? NUM_GROUPS : 32'(grps_q);

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign clear_all = cfg_we && (cfg_idx_t'(cfg_index) == CFG_BPG);

	// the scanner must be idle as well, it may still be clearing the bitmap
	assign in_stall  = !(state_q == T_IDLE && scan_res.rdy);
	assign in_accept = in_valid && !in_stall;
	assign in_range  = (32'(group) < grps_eff) && (32'(group) < NUM_GROUPS);

	assign scan_req.start  = in_accept && in_range;
	assign scan_req.clear  = clear_all;
	assign scan_req.group  = group;
	assign scan_req.nbytes = bpg_eff[BPG_W-1:BIT_W];

	// result register is free, or its transaction completes this cycle
	assign out_load = (state_q == T_FIN) && (!out_valid_q || !out_stall);

	// results of this request; found from the scanner is stale when out of range
	assign gidx      = GIDX_W'(group_q);
	assign fin_found = in_range_q && scan_res.found;
	assign gfc_cur   = gfc_q[gidx];
	assign gfc_nxt   = (fin_found && gfc_cur != '0) ? gfc_cur - BPG_W'(1) : gfc_cur;
	assign tot_nxt   = (fin_found && total_q != '0) ? total_q - TOT_W'(1) : total_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (in_accept) begin
					state_d = in_range ? T_SCAN : T_FIN;
				end
			end
			T_SCAN: begin
				if (scan_res.done) begin
					state_d = T_FIN;
				end
			end
			T_FIN: begin
				if (out_load) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
		// a blocks_per_group write restarts everything
		if (clear_all) begin
			state_d = T_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			bpg_q       <= BPG_W'(BPG_RESET);
			grps_q      <= GRPS_W'(GROUPS_RESET);
			total_q     <= TOT_W'(RST_TOT);
			out_valid_q <= 1'b0;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				gfc_q[g] <= BPG_W'(RST_EFF);
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				total_q <= tot_nxt;
				if (in_range_q) begin
					gfc_q[gidx] <= gfc_nxt;
				end
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_BPG: begin
						bpg_q   <= cfg_data[BPG_W-1:0];
						total_q <= TOT_W'(grps_eff * 32'(bpg_new_eff));
						for (int g = 0; g < NUM_GROUPS; g++) begin
							gfc_q[g] <= bpg_new_eff;
						end
					end
					CFG_GROUPS: begin
						grps_q <= cfg_data[GRPS_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			group_q    <= group;
			in_range_q <= in_range;
			base_q     <= BLK_W'(32'(group) * 32'(bpg_eff));
		end
		if (out_load) begin
			found_q <= fin_found;
			blk_q   <= fin_found
				? BLK_W'(base_q + BLK_W'({scan_res.byte_idx, scan_res.bit_idx}))
				: '0;
			gleft_q <= in_range_q ? gfc_nxt : '0;
			tleft_q <= tot_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign block_number    = blk_q;
	assign group_free_left = gleft_q;
	assign total_free_left = tleft_q;

	`BGBA_ASSERT(a_out_from_fin, clk, arst_n,
		$rose(out_valid_q) |-> ($past(state_q) == T_FIN),
		"result shown without a finished request")
	`BGBA_ASSERT(a_miss_zero, clk, arst_n, (out_valid_q && !found_q) |-> (blk_q == '0),
		"block number not zero on a miss")
	`BGBA_ASSERT_NEVER(a_scan_lost, clk, arst_n, state_q == T_SCAN && scan_res.rdy,
		"waiting on a scanner that is idle")

endmodule

@@ test/block_group_bitmap_allocator_tb.sv @@
// Self-checking bench for the first-fit block group allocator.
// A scoreboard object keeps its own copy of the bitmaps, the free counters and
// the two registers, predicts each grant when the request is taken, and checks
// the grants in arrival order. Plain tasks drive the request and config channels.
// A free-running sink process applies random stall on the result channel.
module block_group_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bgba_pkg::*;

	localparam int NUM_GROUPS = 16;
	localparam int MAX_BPG    = 8192;
	localparam int ROW_BYTES  = MAX_BPG / 8;

	// Worst legal run: ~600 requests each scanning a full group of 8192 blocks plus
	// idle gaps on both sides, and about a dozen bitmap clears. The limit allows
	// roughly three times that run.
	localparam int CYCLE_LIMIT = 3_000_000;
	// Longest single scan (full group at max size) plus margin.
	localparam int TAIL_CYCLES = MAX_BPG / 8 + 64;
	localparam int SHOW_LIMIT  = 10;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 70;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] block_number;
		logic [BPG_W-1:0] group_free_left;
		logic [TOT_W-1:0] total_free_left;
	} grant_t;

	// Allocation tracker: mirrors bitmap and counters, queues predicted grants.
	class alloc_tracker;
		logic [BPG_W-1:0]  bpg_reg;
		logic [GRPS_W-1:0] groups_reg;
		logic [7:0]        bitmap [NUM_GROUPS][ROW_BYTES];
		int unsigned       group_free [NUM_GROUPS];
		int unsigned       total_free;
		grant_t            grants_due [$];
		int                errors;

		function new();
			bpg_reg    = BPG_W'(BPG_RESET);
			groups_reg = GRPS_W'(GROUPS_RESET);
			errors     = 0;
			wipe();
		endfunction

		// Saturate to the row size, then round down to whole bytes.
		function int unsigned blocks_eff();
			int unsigned b;
			b = bpg_reg;
			if (b > MAX_BPG)
				b = MAX_BPG;
			return b - (b % 8);
		endfunction

		function int unsigned groups_eff();
			return (groups_reg > NUM_GROUPS) ? NUM_GROUPS : groups_reg;
		endfunction

		// Total is latched from the groups value in force right now.
		function void wipe();
			int unsigned b;
			b = blocks_eff();
			foreach (bitmap[g, i])
				bitmap[g][i] = 8'h00;
			foreach (group_free[g])
				group_free[g] = b;
			total_free = groups_eff() * b;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_BPG) begin
				bpg_reg = data;
				wipe();
			end else if (idx == CFG_GROUPS) begin
				groups_reg = data[GRPS_W-1:0];
			end
		endfunction

		function void note_request(logic [GROUP_W-1:0] g);
			grant_t      r;
			int unsigned b;
			logic [7:0]  v;
			bit          hit;
			r   = '0;
			hit = 1'b0;
			b   = blocks_eff();
			if (g < groups_eff()) begin
				for (int i = 0; i < b / 8 && !hit; i++) begin
					v = bitmap[g][i];
					if (v != FULL_BYTE) begin
						for (int j = 0; j < 8 && !hit; j++) begin
							if (!v[j]) begin
								bitmap[g][i] = v | (8'h01 << j);
								// counters floor at zero
								if (group_free[g] > 0)
									group_free[g]--;
								if (total_free > 0)
									total_free--;
								r.found        = 1'b1;
								r.block_number = BLK_W'(g * b + i * 8 + j);
								hit            = 1'b1;
							end
						end
					end
				end
				r.group_free_left = BPG_W'(group_free[g]);
			end
			r.total_free_left = TOT_W'(total_free);
			grants_due.push_back(r);
		endfunction

		function void check_grant(grant_t got);
			grant_t want;
			if (grants_due.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("unexpected grant: found=%0d blk=%0d gfree=%0d tfree=%0d",
						got.found, got.block_number, got.group_free_left,
						got.total_free_left);
				return;
			end
			want = grants_due.pop_front();
			if (got.found !== want.found || got.block_number !== want.block_number ||
					got.group_free_left !== want.group_free_left ||
					got.total_free_left !== want.total_free_left) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("grant mismatch: exp found=%0d blk=%0d gfree=%0d tfree=%0d, got found=%0d blk=%0d gfree=%0d tfree=%0d",
						want.found, want.block_number, want.group_free_left,
						want.total_free_left, got.found, got.block_number,
						got.group_free_left, got.total_free_left);
			end
		endfunction

		function int pending();
			return grants_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [GROUP_W-1:0]    req_group;
	logic                  out_valid;
	logic                  out_stall;
	logic                  found;
	logic [BLK_W-1:0]      block_number;
	logic [BPG_W-1:0]      group_free_left;
	logic [TOT_W-1:0]      total_free_left;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Per-phase ceilings for the random idle draws; 0 gives a full-rate stretch.
	int in_gap_max = 7;
	int stall_max  = 7;

	alloc_tracker tracker = new();

	block_group_bitmap_allocator #(
		.NUM_GROUPS          (NUM_GROUPS),
		.MAX_BLOCKS_PER_GROUP(MAX_BPG)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.group          (req_group),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.block_number   (block_number),
		.group_free_left(group_free_left),
		.total_free_left(total_free_left),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("block_group_bitmap_allocator_tb: done, errors");
		$finish;
	end

	// Every handshake is observed at the rising edge, before the DUT's
	// nonblocking updates land, so the sampled values are the pre-edge ones.
	// Results are checked before the same-edge request is noted; a request
	// can never produce its grant on the edge it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_grant(grant_t'({found, block_number, group_free_left,
					total_free_left}));
			if (in_valid && !in_stall)
				tracker.note_request(req_group);
			if (cfg_valid && cfg_ready)
				tracker.configure(cfg_index, cfg_data);
		end
	end

	// Result sink: before each grant, hold stall for a random stretch up to stall_max,
	// then drop it and wait for the transaction. Stall also lands while the
	// DUT is still scanning, so gaps fall on every phase of the work.
	initial begin : result_sink
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = $urandom_range(stall_max, 0);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Bitmap clear runs after reset and after every blocks_per_group write,
	// with in_stall high throughout. Let it start, then wait for in_stall to fall.
	task automatic wait_clear();
		repeat (4) @(negedge clk);
		while (in_stall) @(negedge clk);
	endtask

	// Entered and left on a falling edge with no pending assignment to
	// in_valid, so a back-to-back request keeps valid high without a glitch.
	task automatic send_request(input logic [GROUP_W-1:0] g);
		int gap;
		gap = $urandom_range(in_gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		req_group <= g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Close the request stream and wait until every predicted grant is back;
	// only then is the block idle and safe to reprogram.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BPG)
			wait_clear();
		else
			@(negedge clk);
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] d;
		logic [GRPS_W-1:0]     ga;
		logic [GRPS_W-1:0]     gb;
		logic [BPG_W-1:0]      bpg;
		int                    lim;
		int                    hot_a;
		int                    hot_b;
		int                    r;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_group = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BPG;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_clear();

		// ---- directed part ----

		// Reset settings: 8192 blocks, 16 groups. Lowest and highest group.
		send_request(GROUP_W'(0));
		send_request(GROUP_W'(0));
		send_request(GROUP_W'(15));
		send_request(GROUP_W'(7));

		// Shrinking groups_in_use leaves counters alone; group 3 is now out
		// of range and reports the current total.
		drain();
		cfg_write(CFG_GROUPS, CFG_DATA_W'(3));
		send_request(GROUP_W'(3));
		send_request(GROUP_W'(2));

		// Smallest group: one byte. Eight grants, then the group is full.
		drain();
		cfg_write(CFG_BPG, CFG_DATA_W'(8));
		for (int k = 0; k < 9; k++)
			send_request(GROUP_W'(0));
		send_request(GROUP_W'(5));

		// Zero blocks per group: nothing can be found.
		drain();
		cfg_write(CFG_BPG, CFG_DATA_W'(0));
		send_request(GROUP_W'(0));

		// Unmapped index is ignored; oversized values saturate, and the upper
		// data bits of a groups write are dropped.
		drain();
		cfg_write(CFG_SPARE, '1);
		cfg_write(CFG_BPG, '1);
		cfg_write(CFG_GROUPS, '1);
		send_request(GROUP_W'(15));

		// No groups in use at all.
		drain();
		cfg_write(CFG_GROUPS, CFG_DATA_W'(14'h3FE0));
		send_request(GROUP_W'(0));

		// ---- random phases ----
		// Each phase sets groups, rewrites blocks_per_group (which latches the
		// total from the current groups), and often changes groups again so the
		// total can drain to zero while groups still have room. Sizes are mostly
		// a few bytes so that hot groups fill up and full-group answers show up.
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			in_gap_max = (p % 3 == 2) ? 0 : 7;
			stall_max  = (p % 4 == 1) ? 0 : 7;

			r = $urandom_range(9, 0);
			if (r < 2)
				ga = GRPS_W'($urandom_range(31, 17));
			else if (r == 2)
				ga = '0;
			else
				ga = GRPS_W'($urandom_range(16, 1));
			d = CFG_DATA_W'($urandom);
			d[GRPS_W-1:0] = ga;
			cfg_write(CFG_GROUPS, d);

			r = $urandom_range(9, 0);
			case (r)
				6: begin
					bpg = BPG_W'($urandom_range(63, 0));
				end
				7: begin
					bpg = BPG_W'($urandom_range(16383, 8192));
				end
				8: begin
					bpg = BPG_W'(8 * $urandom_range(1024, 1));
				end
				9: begin
					bpg = BPG_W'($urandom_range(16383, 0));
				end
				default: begin
					bpg = BPG_W'(8 * $urandom_range(6, 1));
				end
			endcase
			cfg_write(CFG_BPG, CFG_DATA_W'(bpg));

			gb = ga;
			if ($urandom_range(1, 0)) begin
				gb = GRPS_W'($urandom_range(31, 1));
				d  = CFG_DATA_W'($urandom);
				d[GRPS_W-1:0] = gb;
				cfg_write(CFG_GROUPS, d);
			end

			// Two hot groups inside the range in force get most requests.
			lim   = (gb > NUM_GROUPS) ? NUM_GROUPS : gb;
			hot_a = (lim > 0) ? $urandom_range(lim - 1, 0) : 0;
			hot_b = (lim > 0) ? $urandom_range(lim - 1, 0) : 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(3, 0);
				if (r == 0)
					send_request(GROUP_W'($urandom_range(15, 0)));
				else if (r == 1)
					send_request(GROUP_W'(hot_a));
				else
					send_request(GROUP_W'(hot_b));
			end
		end

		// ---- wind down ----
		// A stray extra grant after the last expected one is caught by the
		// checker during the tail.
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.errors == 0)
			$display("block_group_bitmap_allocator_tb: done, clean");
		else
			$display("block_group_bitmap_allocator_tb: done, errors");
		$finish;
	end

endmodule
